// ===== rtl/core/mrs_pkg.sv =====
// Shared types, codes and CRC helper for the Modbus RTU slave frame handler.
package mrs_pkg;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last_byte;
		logic [2:0] frame_status;
		logic       params_written;
		logic       time_written;
		logic [2:0] time_index;
	} out_item_t;

	localparam logic       KIND_BYTE = 1'b0;
	localparam logic       KIND_TICK = 1'b1;

	localparam logic       CFG_SLAVE_ADDR = 1'b0;
	localparam logic       CFG_SILENCE_MS = 1'b1;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_UNK_FUNC = 3'd1;
	localparam logic [2:0] ST_CRC      = 3'd2;
	localparam logic [2:0] ST_OTHER    = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;
	localparam logic [2:0] ST_RANGE    = 3'd5;

	localparam logic [7:0] FN_READ_COILS = 8'd1;
	localparam logic [7:0] FN_READ_REGS  = 8'd3;
	localparam logic [7:0] FN_WRITE_ONE  = 8'd6;
	localparam logic [7:0] FN_WRITE_MANY = 8'd16;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [15:0] TIME_REG_LO = 16'd10;
	localparam logic [15:0] TIME_REG_HI = 16'd16;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/mrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/mrs_ctrl.sv =====
// Frame sequencer: receive, check, register file access and response output.
module mrs_ctrl #(
	parameter int RX_DEPTH  = 256,
	parameter int REG_WORDS = 256,
	parameter int MAX_READ  = 29,
	parameter int MAX_WRITE = 89
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_sel,
	input  logic [9:0]                   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  mrs_pkg::in_item_t            in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output mrs_pkg::out_item_t           out_data,
	output logic                         fr_we,
	output logic [$clog2(RX_DEPTH)-1:0]  fr_waddr,
	output logic [7:0]                   fr_wdata,
	output logic [$clog2(RX_DEPTH)-1:0]  fr_raddr,
	input  logic [7:0]                   fr_rdata,
	output logic                         rf_we,
	output logic [$clog2(REG_WORDS)-1:0] rf_waddr,
	output logic [15:0]                  rf_wdata,
	output logic [$clog2(REG_WORDS)-1:0] rf_raddr,
	input  logic [15:0]                  rf_rdata
);
	import mrs_pkg::*;

	localparam int FA_W  = $clog2(RX_DEPTH);
	localparam int RA_W  = $clog2(REG_WORDS);
	localparam int LEN_W = $clog2(5 + 2 * MAX_READ + 1);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_WLOAD  = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;
	localparam logic [2:0] S_RWAIT  = 3'd6;

	localparam logic [1:0] M_STAT  = 2'd0;
	localparam logic [1:0] M_READ  = 2'd1;
	localparam logic [1:0] M_WRITE = 2'd2;

	logic [2:0]       state_q;
	logic [7:0]       slave_q;
	logic [9:0]       sil_ms_q;
	logic [8:0]       count_q;
	logic             ovf_q;
	logic [9:0]       sil_q;
	logic [RA_W-1:0]  clr_q;
	logic [8:0]       rd_idx_q;
	logic [8:0]       rd_last_q;
	logic             issue_done_q;
	logic             vld_s1;
	logic [8:0]       idx_s1;
	logic [7:0]       f_q [6];
	logic [7:0]       clo_q;
	logic [7:0]       chi_q;
	logic [15:0]      crc_q;
	logic [1:0]       mode_q;
	logic [2:0]       st_q;
	logic             pw_q;
	logic             tw_q;
	logic [2:0]       ti_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] e_idx_q;
	logic [15:0]      word_q;
	logic             word_ok_q;
	logic [RA_W-1:0]  rf_ptr_q;
	logic [7:0]       hi_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic        acc;
	logic        fire;
	logic [15:0] addr16;
	logic [15:0] qty16;
	logic [16:0] range_end;
	logic [17:0] need_len;
	logic        crc_ok;
	logic        time_hit;
	logic        in_data_rng;
	logic        need_word;
	logic        is_last;
	logic        is_data;
	out_item_t   item;

	assign acc       = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign fire      = !out_valid_q || !out_stall;

	assign addr16    = {f_q[2], f_q[3]};
	assign qty16     = {f_q[4], f_q[5]};
	assign range_end = {1'b0, addr16} + {1'b0, qty16};
	assign need_len  = 18'd9 + {1'b0, qty16, 1'b0};
	assign crc_ok    = (clo_q == crc_q[7:0]) && (chi_q == crc_q[15:8]);
	assign time_hit  = (addr16 >= TIME_REG_LO) && (addr16 <= TIME_REG_HI);

	assign fr_we    = acc && (in_data.kind == KIND_BYTE) && (count_q < 9'(RX_DEPTH));
	assign fr_waddr = count_q[FA_W-1:0];
	assign fr_wdata = in_data.rx_byte;
	assign fr_raddr = rd_idx_q[FA_W-1:0];
	assign rf_raddr = rf_ptr_q;

	// Register file write port: clearing sweep, single write, block write.
	always_comb begin
		rf_we    = 1'b0;
		rf_waddr = rf_ptr_q;
		rf_wdata = {hi_q, fr_rdata};
		unique case (state_q)
			S_CLEAR: begin
				rf_we    = 1'b1;
				rf_waddr = clr_q;
				rf_wdata = 16'h0000;
			end
			S_DECIDE: begin
				rf_we = !ovf_q && (f_q[0] == slave_q) && (count_q >= 9'd4) && crc_ok
					&& (f_q[1] == FN_WRITE_ONE) && (count_q >= 9'd8)
					&& ({1'b0, addr16} < 17'(REG_WORDS));
				rf_waddr = addr16[RA_W-1:0];
				rf_wdata = qty16;
			end
			S_WLOAD: begin
				rf_we = vld_s1 && !idx_s1[0];
			end
			default: begin
				rf_we = 1'b0;
			end
		endcase
	end

	// Next response byte.
	always_comb begin
		in_data_rng = (e_idx_q >= LEN_W'(3)) && (e_idx_q < len_q);
		need_word   = (mode_q == M_READ) && in_data_rng && e_idx_q[0] && !word_ok_q;
		is_data     = (mode_q != M_STAT) && (e_idx_q < len_q);
		is_last     = (mode_q == M_STAT) || (e_idx_q == LEN_W'(len_q + LEN_W'(1)));
		item.last_byte      = is_last;
		item.frame_status   = (mode_q == M_STAT) ? st_q : ST_OK;
		item.params_written = pw_q;
		item.time_written   = tw_q;
		item.time_index     = ti_q;
		if (mode_q == M_STAT) begin
			item.tx_byte = 8'h00;
		end else if (e_idx_q == len_q) begin
			item.tx_byte = crc_q[7:0];
		end else if (!is_data) begin
			item.tx_byte = crc_q[15:8];
		end else if (e_idx_q == LEN_W'(0)) begin
			item.tx_byte = slave_q;
		end else if (mode_q == M_READ) begin
			if (e_idx_q == LEN_W'(1)) begin
				item.tx_byte = FN_READ_REGS;
			end else if (e_idx_q == LEN_W'(2)) begin
				item.tx_byte = {qty16[6:0], 1'b0};
			end else begin
				item.tx_byte = e_idx_q[0] ? word_q[15:8] : word_q[7:0];
			end
		end else begin
			item.tx_byte = f_q[e_idx_q[2:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			slave_q      <= 8'd2;
			sil_ms_q     <= 10'd3;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			sil_q        <= '0;
			clr_q        <= '0;
			issue_done_q <= 1'b0;
			vld_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
			word_ok_q    <= 1'b0;
			mode_q       <= M_STAT;
			e_idx_q      <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_sel == CFG_SLAVE_ADDR) begin
					slave_q <= cfg_wdata[7:0];
				end else begin
					sil_ms_q <= cfg_wdata;
				end
			end
			if (fire) begin
				out_valid_q <= 1'b0;
			end
			vld_s1 <= 1'b0;

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + RA_W'(1);
					if (clr_q == RA_W'(REG_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc) begin
						if (in_data.kind == KIND_BYTE) begin
							if (count_q < 9'(RX_DEPTH)) begin
								count_q <= count_q + 9'd1;
							end else begin
								ovf_q <= 1'b1;
							end
							sil_q <= '0;
						end else if (count_q != 9'd0) begin
							if (sil_q < sil_ms_q) begin
								sil_q <= sil_q + 10'd1;
							end else begin
								// Close the frame: walk header, body and CRC.
								state_q      <= S_SCAN;
								rd_idx_q     <= '0;
								rd_last_q    <= (count_q < 9'd6) ? 9'd5 : count_q - 9'd1;
								issue_done_q <= 1'b0;
								crc_q        <= CRC_INIT;
							end
						end
					end
				end
				S_SCAN: begin
					if (!issue_done_q) begin
						vld_s1   <= 1'b1;
						idx_s1   <= rd_idx_q;
						rd_idx_q <= rd_idx_q + 9'd1;
						if (rd_idx_q == rd_last_q) begin
							issue_done_q <= 1'b1;
						end
					end
					if (vld_s1) begin
						for (int i = 0; i < 6; i++) begin
							if (idx_s1 == 9'(i)) begin
								f_q[i] <= fr_rdata;
							end
						end
						if ({1'b0, idx_s1} + 10'd2 < {1'b0, count_q}) begin
							crc_q <= crc_byte(crc_q, fr_rdata);
						end
						if ({1'b0, idx_s1} + 10'd2 == {1'b0, count_q}) begin
							clo_q <= fr_rdata;
						end
						if ({1'b0, idx_s1} + 10'd1 == {1'b0, count_q}) begin
							chi_q <= fr_rdata;
						end
						if (idx_s1 == rd_last_q) begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					count_q   <= '0;
					ovf_q     <= 1'b0;
					sil_q     <= '0;
					crc_q     <= CRC_INIT;
					e_idx_q   <= '0;
					word_ok_q <= 1'b0;
					pw_q      <= 1'b0;
					tw_q      <= 1'b0;
					ti_q      <= 3'd0;
					mode_q    <= M_STAT;
					state_q   <= S_EMIT;
					rf_ptr_q  <= addr16[RA_W-1:0];
					priority if (ovf_q) begin
						st_q <= ST_OVERFLOW;
					end else if (f_q[0] != slave_q) begin
						st_q <= ST_OTHER;
					end else if (count_q < 9'd4 || !crc_ok) begin
						st_q <= ST_CRC;
					end else if (f_q[1] == FN_READ_COILS) begin
						// Accepted but silent.
						state_q <= S_IDLE;
					end else if (f_q[1] == FN_READ_REGS) begin
						if (count_q < 9'd8 || qty16 == 16'd0 || qty16 > 16'(MAX_READ)
								|| range_end > 17'(REG_WORDS)) begin
							st_q <= ST_RANGE;
						end else begin
							mode_q <= M_READ;
							len_q  <= LEN_W'({qty16[LEN_W-2:0], 1'b0}) + LEN_W'(3);
						end
					end else if (f_q[1] == FN_WRITE_ONE || f_q[1] == FN_WRITE_MANY) begin
						if ((f_q[1] == FN_WRITE_ONE && (count_q < 9'd8
								|| {1'b0, addr16} >= 17'(REG_WORDS)))
							|| (f_q[1] == FN_WRITE_MANY && (qty16 == 16'd0
								|| qty16 > 16'(MAX_WRITE) || range_end > 17'(REG_WORDS)
								|| {9'd0, count_q} < need_len))) begin
							st_q <= ST_RANGE;
						end else begin
							mode_q <= M_WRITE;
							len_q  <= LEN_W'(6);
							pw_q   <= 1'b1;
							tw_q   <= time_hit;
							ti_q   <= time_hit ? 3'(addr16 - TIME_REG_LO) : 3'd0;
							if (f_q[1] == FN_WRITE_MANY) begin
								state_q      <= S_WLOAD;
								rd_idx_q     <= 9'd7;
								rd_last_q    <= 9'(need_len - 18'd3);
								issue_done_q <= 1'b0;
							end
						end
					end else begin
						st_q <= ST_UNK_FUNC;
					end
				end
				S_WLOAD: begin
					if (!issue_done_q) begin
						vld_s1   <= 1'b1;
						idx_s1   <= rd_idx_q;
						rd_idx_q <= rd_idx_q + 9'd1;
						if (rd_idx_q == rd_last_q) begin
							issue_done_q <= 1'b1;
						end
					end
					if (vld_s1) begin
						if (idx_s1[0]) begin
							hi_q <= fr_rdata;
						end else begin
							rf_ptr_q <= rf_ptr_q + RA_W'(1);
						end
						if (idx_s1 == rd_last_q) begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (need_word) begin
						rf_ptr_q <= rf_ptr_q + RA_W'(1);
						state_q  <= S_RWAIT;
					end else if (fire) begin
						out_q       <= item;
						out_valid_q <= 1'b1;
						e_idx_q     <= e_idx_q + LEN_W'(1);
						if (is_data) begin
							crc_q <= crc_byte(crc_q, item.tx_byte);
						end
						if (in_data_rng && !e_idx_q[0]) begin
							word_ok_q <= 1'b0;
						end
						if (is_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RWAIT: begin
					word_q    <= rf_rdata;
					word_ok_q <= 1'b1;
					state_q   <= S_EMIT;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== rtl/core/modbus_rtu_slave_frame_handler_top.sv =====
// Top level of the Modbus RTU slave frame handler: sequencer and two RAMs.
//
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall   | in_data (kind, rx_byte)
// out     | output    | out_valid / out_stall | out_data (response byte and status)
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// In the idle state every received byte and non-closing tick is accepted; otherwise input stalls.
// A closing tick walks the frame store, then emits one result byte per cycle while the output
// does not stall, reading a register before each word; a block write loads its words first.
// After reset a clearing pass zeroes every register file word; requests wait.
// A stalled output holds the sequencer; configuration writes are taken in every cycle.
module modbus_rtu_slave_frame_handler_top #(
	parameter int RX_DEPTH  = 256,
	parameter int REG_WORDS = 256,
	parameter int MAX_READ  = 29,
	parameter int MAX_WRITE = 89
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mrs_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output mrs_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [9:0]         cfg_data
);
	import mrs_pkg::*;

	localparam int FA_W = $clog2(RX_DEPTH);
	localparam int RA_W = $clog2(REG_WORDS);

	logic            fr_we;
	logic [FA_W-1:0] fr_waddr;
	logic [7:0]      fr_wdata;
	logic [FA_W-1:0] fr_raddr;
	logic [7:0]      fr_rdata;
	logic            rf_we;
	logic [RA_W-1:0] rf_waddr;
	logic [15:0]     rf_wdata;
	logic [RA_W-1:0] rf_raddr;
	logic [15:0]     rf_rdata;

	assign cfg_ready = 1'b1;

	mrs_ctrl #(
		.RX_DEPTH (RX_DEPTH),
		.REG_WORDS(REG_WORDS),
		.MAX_READ (MAX_READ),
		.MAX_WRITE(MAX_WRITE)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_sel  (cfg_index),
		.cfg_wdata(cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.fr_we    (fr_we),
		.fr_waddr (fr_waddr),
		.fr_wdata (fr_wdata),
		.fr_raddr (fr_raddr),
		.fr_rdata (fr_rdata),
		.rf_we    (rf_we),
		.rf_waddr (rf_waddr),
		.rf_wdata (rf_wdata),
		.rf_raddr (rf_raddr),
		.rf_rdata (rf_rdata)
	);

	mrs_ram #(
		.WIDTH(8),
		.DEPTH(RX_DEPTH)
	) u_frame_ram (
		.clk  (clk),
		.we   (fr_we),
		.waddr(fr_waddr),
		.wdata(fr_wdata),
		.raddr(fr_raddr),
		.rdata(fr_rdata)
	);

	mrs_ram #(
		.WIDTH(16),
		.DEPTH(REG_WORDS)
	) u_reg_ram (
		.clk  (clk),
		.we   (rf_we),
		.waddr(rf_waddr),
		.wdata(rf_wdata),
		.raddr(rf_raddr),
		.rdata(rf_rdata)
	);
endmodule
